FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL modules of the substring search block.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define NSOS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define NSOS_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define NSOS_ASSERT(lbl, prop, msg)
`define NSOS_NEVER(lbl, expr, msg)
`endif
`endif

FILE: rtl/nsos_pkg.sv
// Types and constants of the substring search block.
// Used by the controller, the datapath and the top level.
`default_nettype none

package nsos_pkg;

  localparam int unsigned HAY_MAX    = 1024;
  localparam int unsigned NEEDLE_MAX = 16;
  localparam int unsigned ADDR_W     = $clog2(HAY_MAX);
  localparam int unsigned LEN_W      = $clog2(HAY_MAX + 1);
  localparam int unsigned POS_W      = 11;
  localparam int unsigned FIELD_W    = 12;
  localparam int unsigned NORM_W     = 14;
  localparam int unsigned NLEN_W     = 5;
  localparam int unsigned FILL_W     = $clog2(NEEDLE_MAX + 1);
  localparam int unsigned NIDX_W     = $clog2(NEEDLE_MAX);
  localparam int unsigned CFG_W      = 64;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LEN  = 2'd2;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;

  typedef struct packed {
    logic [1:0]                mode;
    logic [7:0]                data_byte;
    logic signed [FIELD_W-1:0] start_pos;
    logic signed [FIELD_W-1:0] span_len;
    logic signed [FIELD_W-1:0] occurrence;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             status;
  } out_t;

  typedef struct packed {
    logic clear;
    logic append;
    logic latch;
    logic norm1;
    logic norm2;
    logic setup;
    logic scan;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic exhausted;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/nth_substring_occurrence_search_top.sv
// Top level of the nth-occurrence substring search block.
// Depends on nsos_pkg, nsos_ctrl, nsos_dp and nsos_ram.
//
// Clear and append transactions do not leave the idle state. An append writes
// the 1024-byte haystack RAM; a clear only resets the stored length, so the
// RAM needs no clearing pass. A search transaction normalizes the segment and
// sets up the scan in three steps (NORM1, NORM2, SETUP), then streams one byte
// a cycle through the single RAM read port into a 16-byte match window, and
// ends when the requested match is found or the segment is exhausted. Only one
// transaction is in work at a time; a finished result waits in the output
// register while the next transaction is taken.
`default_nettype none

module nth_substring_occurrence_search_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [nsos_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [nsos_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire nsos_pkg::in_t                  in_data_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      nsos_pkg::out_t                 out_data_o
);

  import nsos_pkg::*;

  cmd_t    cmd;
  status_t status;

  nsos_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_mode_i   (in_data_i.mode),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  nsos_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

FILE: rtl/nsos_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module nsos_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/nsos_ctrl.sv
// Sequencing controller of the substring search block.
// Depends on nsos_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module nsos_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire logic [1:0]        in_mode_i,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      nsos_pkg::cmd_t    cmd_o,
  input  wire nsos_pkg::status_t status_i
);

  import nsos_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM1,
    S_NORM2,
    S_SETUP,
    S_SCAN,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.norm1    = (state_q == S_NORM1);
    cmd_o.norm2    = (state_q == S_NORM2);
    cmd_o.setup    = (state_q == S_SETUP);
    cmd_o.scan     = (state_q == S_SCAN);
    cmd_o.out_load = (state_q == S_DONE) && out_free;
    if (accept) begin
      case (in_mode_i)
        MODE_CLEAR:  cmd_o.clear  = 1'b1;
        MODE_APPEND: cmd_o.append = 1'b1;
        MODE_SEARCH: cmd_o.latch  = 1'b1;
        default:     ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (cmd_o.latch) begin
          state_d = S_NORM1;
        end
      end
      S_NORM1: state_d = S_NORM2;
      S_NORM2: state_d = S_SETUP;
      S_SETUP: state_d = S_SCAN;
      S_SCAN: begin
        if (status_i.found || status_i.exhausted) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `NSOS_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE), "result without search")
  `NSOS_ASSERT(a_scan_exit, (state_q == S_SCAN) |=> (state_q == S_SCAN || state_q == S_DONE), "bad scan exit")
  `NSOS_ASSERT(a_done_leave, (state_q == S_DONE && out_free) |=> (state_q == S_IDLE && out_valid_q), "result lost")

endmodule

`default_nettype wire

FILE: rtl/nsos_dp.sv
// Datapath of the substring search block: needle registers, haystack RAM,
// segment normalization and the streaming match window.
// Depends on nsos_pkg, nsos_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module nsos_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [nsos_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [nsos_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire nsos_pkg::in_t                  in_data_i,
  input  wire nsos_pkg::cmd_t                 cmd_i,
  output      nsos_pkg::status_t              status_o,
  output      nsos_pkg::out_t                 out_data_o
);

  import nsos_pkg::*;

  logic [CFG_W-1:0]  needle_low_q, needle_high_q;
  logic [NLEN_W-1:0] needle_len_q;
  logic [LEN_W-1:0]  stored_len_q;

  logic signed [FIELD_W-1:0] beg_q, len_q;
  logic [FIELD_W-1:0]        occ_u, occ_mag_q, occ_mag_d;
  logic                      back_q, bad_q;
  logic [FILL_W-1:0]         nsat_q, nsat_d;

  logic signed [NORM_W-1:0] lenh_s, beg_s, len_s, sum_s;
  logic signed [NORM_W-1:0] b0_q, b0_d, l0_q, l0_d;
  logic                     lz_q;
  logic [POS_W-1:0]         nb_q, nb_d, nl_q, nl_d;
  logic                     triv_q, triv_d;

  logic [2*CFG_W-1:0] needle_cat;
  logic [7:0]         needle_b [NEEDLE_MAX];
  logic [7:0]         pat_q [NEEDLE_MAX];
  logic [7:0]         pat_d [NEEDLE_MAX];
  logic [7:0]         win_q [NEEDLE_MAX];
  logic [7:0]         win_d [NEEDLE_MAX];
  logic [NEEDLE_MAX-1:0] byte_ok;

  logic [POS_W-1:0]   addr_q, left_q, rd_pos_q, res_pos_q, pos_hit;
  logic               rd_valid_q;
  logic [FILL_W-1:0]  fill_q, fill_inc;
  logic [FIELD_W-1:0] hits_q;
  logic [7:0]         rd_data;
  logic               issue, proc, match, hit_final;
  out_t               out_q;

  assign issue = cmd_i.scan && (left_q != '0);
  assign proc  = cmd_i.scan && rd_valid_q;

  nsos_ram #(
    .WIDTH (8),
    .DEPTH (HAY_MAX)
  ) u_hay_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.append && (stored_len_q < LEN_W'(HAY_MAX))),
    .waddr_i (stored_len_q[ADDR_W-1:0]),
    .wdata_i (in_data_i.data_byte),
    .re_i    (issue),
    .raddr_i (addr_q[ADDR_W-1:0]),
    .rdata_o (rd_data)
  );

  // segment normalization
  assign occ_u     = in_data_i.occurrence;
  assign occ_mag_d = occ_u[FIELD_W-1] ? (~occ_u + FIELD_W'(1)) : occ_u;
  assign nsat_d    = (needle_len_q > NLEN_W'(NEEDLE_MAX)) ? FILL_W'(NEEDLE_MAX)
                                                          : FILL_W'(needle_len_q);

  assign lenh_s = $signed({{(NORM_W-LEN_W){1'b0}}, stored_len_q});
  assign beg_s  = $signed({{(NORM_W-FIELD_W){beg_q[FIELD_W-1]}}, beg_q});
  assign len_s  = $signed({{(NORM_W-FIELD_W){len_q[FIELD_W-1]}}, len_q});
  assign sum_s  = b0_q + l0_q;

  always_comb begin
    if (beg_q == '0) begin
      b0_d = '0;
    end else if (beg_q[FIELD_W-1]) begin
      b0_d = lenh_s + beg_s;
    end else begin
      b0_d = beg_s - NORM_W'(1);
    end
    l0_d = (len_q == '0) ? lenh_s : len_s;
  end

  always_comb begin
    if (b0_q[NORM_W-1]) begin
      nb_d = '0;
      if (lz_q) begin
        nl_d = stored_len_q;
      end else if (sum_s[NORM_W-1]) begin
        nl_d = '0;
      end else begin
        nl_d = sum_s[POS_W-1:0];
      end
    end else begin
      nb_d = b0_q[POS_W-1:0];
      if (b0_q > lenh_s) begin
        nl_d = '0;
      end else if (sum_s > lenh_s) begin
        nl_d = POS_W'(lenh_s - b0_q);
      end else begin
        nl_d = l0_q[POS_W-1:0];
      end
    end
    triv_d = bad_q || (occ_mag_q == '0) || (nsat_q == '0) || (nl_d == '0)
             || (POS_W'(nsat_q) > nl_d);
  end

  assign needle_cat = {needle_high_q, needle_low_q};

  // needle bytes, reversed for a forward scan
  always_comb begin
    for (int i = 0; i < NEEDLE_MAX; i++) begin
      needle_b[i] = needle_cat[8*i +: 8];
    end
    for (int j = 0; j < NEEDLE_MAX; j++) begin
      if (back_q) begin
        pat_d[j] = needle_b[j];
      end else begin
        pat_d[j] = needle_b[NIDX_W'(nsat_q - FILL_W'(1) - FILL_W'(j))];
      end
    end
  end

  // match window, newest byte at index zero
  always_comb begin
    win_d[0] = rd_data;
    for (int k = 1; k < NEEDLE_MAX; k++) begin
      win_d[k] = win_q[k-1];
    end
    for (int j = 0; j < NEEDLE_MAX; j++) begin
      byte_ok[j] = (FILL_W'(j) >= nsat_q) || (win_d[j] == pat_q[j]);
    end
    fill_inc  = (fill_q == FILL_W'(NEEDLE_MAX)) ? fill_q : fill_q + FILL_W'(1);
    match     = proc && (fill_inc >= nsat_q) && (&byte_ok);
    hit_final = match && ((hits_q + FIELD_W'(1)) == occ_mag_q);
    pos_hit   = back_q ? rd_pos_q + POS_W'(1)
                       : rd_pos_q - POS_W'(nsat_q) + POS_W'(2);
  end

  assign status_o.found     = hit_final;
  assign status_o.exhausted = (left_q == '0) && !rd_valid_q;
  assign out_data_o         = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_low_q  <= '0;
      needle_high_q <= '0;
      needle_len_q  <= '0;
      stored_len_q  <= '0;
      rd_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_NEEDLE_LOW:  needle_low_q  <= cfg_data_i;
          REG_NEEDLE_HIGH: needle_high_q <= cfg_data_i;
          REG_NEEDLE_LEN:  needle_len_q  <= cfg_data_i[NLEN_W-1:0];
          default:         ;
        endcase
      end
      if (cmd_i.clear) begin
        stored_len_q <= '0;
      end else if (cmd_i.append && (stored_len_q < LEN_W'(HAY_MAX))) begin
        stored_len_q <= stored_len_q + LEN_W'(1);
      end
      rd_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_pos_q <= addr_q;
    if (cmd_i.latch) begin
      beg_q     <= in_data_i.start_pos;
      len_q     <= in_data_i.span_len;
      bad_q     <= in_data_i.span_len[FIELD_W-1];
      back_q    <= occ_u[FIELD_W-1];
      occ_mag_q <= occ_mag_d;
      nsat_q    <= nsat_d;
    end
    if (cmd_i.norm1) begin
      b0_q <= b0_d;
      l0_q <= l0_d;
      lz_q <= (len_q == '0);
    end
    if (cmd_i.norm2) begin
      nb_q   <= nb_d;
      nl_q   <= nl_d;
      triv_q <= triv_d;
    end
    if (cmd_i.setup) begin
      addr_q    <= back_q ? nb_q + nl_q - POS_W'(1) : nb_q;
      left_q    <= triv_q ? '0 : nl_q;
      hits_q    <= '0;
      fill_q    <= '0;
      res_pos_q <= '0;
      pat_q     <= pat_d;
    end
    if (issue) begin
      addr_q <= back_q ? addr_q - POS_W'(1) : addr_q + POS_W'(1);
      left_q <= left_q - POS_W'(1);
    end
    if (proc) begin
      win_q  <= win_d;
      fill_q <= match ? '0 : fill_inc;
      if (match) begin
        hits_q <= hits_q + FIELD_W'(1);
      end
      if (hit_final) begin
        res_pos_q <= pos_hit;
      end
    end
    if (cmd_i.out_load) begin
      out_q.position <= res_pos_q;
      out_q.status   <= bad_q;
    end
  end

  `NSOS_NEVER(a_len_bound, stored_len_q > LEN_W'(HAY_MAX), "stored length overflow")
  `NSOS_NEVER(a_fill_bound, cmd_i.scan && (fill_q > FILL_W'(NEEDLE_MAX)), "window fill overflow")
  `NSOS_ASSERT(a_rd_follows_scan, rd_valid_q |-> $past(cmd_i.scan), "read without scan")
  `NSOS_ASSERT(a_found_pos, status_o.found |=> (res_pos_q != '0), "found at zero")

endmodule

`default_nettype wire

FILE: tb/tb_nth_substring_occurrence_search_top.sv
`timescale 1ns / 1ps
// Testbench for nth_substring_occurrence_search_top: clear, append and search transactions
// under random idling and stalls, each result checked against a built-in search predictor
// or a fixed expected value. Depends on nsos_pkg and the block's RTL.
module tb_nth_substring_occurrence_search_top;
  import nsos_pkg::*;

  localparam int CYCLE_LIMIT  = 10_000_000;
  localparam int RANDOM_ITEMS = 900;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    in_t  item;
    bit   fixed;
    out_t result;
  } stim_row_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = REG_NEEDLE_LOW;
  logic [CFG_W-1:0]     cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_t                  in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_t                 out_data_o;

  logic [7:0]        hay_mem [HAY_MAX];
  int                hay_len = 0;
  int                hay_hw = 0;
  logic [CFG_W-1:0]  needle_lo = '0;
  logic [CFG_W-1:0]  needle_hi = '0;
  logic [NLEN_W-1:0] needle_len = '0;
  out_t              pending_results[$];
  stim_row_t         dir_rows[$];
  int                err_count = 0;
  int                cycle_count = 0;
  bit                quiet = 1'b0;
  bit                hold_pending = 1'b0;
  int                hold_left = 0;
  int                stall_left = 0;
  bit                stall_state = 1'b0;

  nth_substring_occurrence_search_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int sx12(logic [FIELD_W-1:0] v);
    return int'($signed(v));
  endfunction

  function automatic bit needle_at(int p, int n);
    logic [2*CFG_W-1:0] nb;
    nb = {needle_hi, needle_lo};
    for (int i = 0; i < n; i++) begin
      if (hay_mem[(p + i) % HAY_MAX] !== nb[8*i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [POS_W-1:0] nth_match(int beg, int len, int occ);
    int lenh, n, hits, p;
    lenh = hay_len;
    n    = needle_len;
    hits = 0;
    if (beg == 0) begin
      if (len == 0 || len > lenh) len = lenh;
    end else if (beg > 0) begin
      beg--;
      if (len == 0) len = lenh;
      if (beg > lenh) len = 0;
      else if (beg + len > lenh) len = lenh - beg;
    end else begin
      beg = lenh + beg;
      if (beg >= 0) begin
        if (len == 0) len = lenh;
        if (beg + len > lenh) len = lenh - beg;
      end else if (len == 0) begin
        beg = 0;
        len = lenh;
      end else if (beg + len < 0) begin
        len = 0;
      end else begin
        len = len + beg;
        beg = 0;
      end
    end
    if (n > int'(NEEDLE_MAX)) n = NEEDLE_MAX;
    if (len <= 0 || n == 0 || occ == 0 || n > len) return '0;
    if (occ > 0) begin
      p = beg;
      while (p <= beg + len - n) begin
        if (needle_at(p, n)) begin
          hits++;
          if (hits == occ) return POS_W'(p + 1);
          p += n;
        end else begin
          p++;
        end
      end
    end else begin
      p = beg + len - n;
      while (p >= beg) begin
        if (needle_at(p, n)) begin
          hits--;
          if (hits == occ) return POS_W'(p + 1);
          p -= n;
        end else begin
          p--;
        end
      end
    end
    return '0;
  endfunction

  function automatic bit apply_transaction(in_t t, output out_t res);
    res = '0;
    case (t.mode)
      MODE_CLEAR: hay_len = 0;
      MODE_APPEND: begin
        if (hay_len < int'(HAY_MAX)) begin
          hay_mem[hay_len] = t.data_byte;
          hay_len++;
          if (hay_len > hay_hw) hay_hw = hay_len;
        end
      end
      MODE_SEARCH: begin
        if (sx12(t.span_len) < 0) res.status = 1'b1;
        else res.position = nth_match(sx12(t.start_pos), sx12(t.span_len),
                                      sx12(t.occurrence));
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 30);
  endfunction

  function automatic in_t make_item(logic [1:0] m, logic [7:0] b, int s, int l, int o);
    in_t t;
    t.mode       = m;
    t.data_byte  = b;
    t.start_pos  = FIELD_W'(s);
    t.span_len   = FIELD_W'(l);
    t.occurrence = FIELD_W'(o);
    return t;
  endfunction

  function automatic void add_row(logic [1:0] m, logic [7:0] b, int s, int l, int o,
                                  bit fixed = 1'b0, int pos = 0, bit st = 1'b0);
    stim_row_t row;
    row.item            = make_item(m, b, s, l, o);
    row.fixed           = fixed;
    row.result.position = POS_W'(pos);
    row.result.status   = st;
    dir_rows.push_back(row);
  endfunction

  function automatic in_t random_search(int lenh);
    int r, s, l, o, span;
    span = (lenh + 3 > 1024) ? 1024 : lenh + 3;
    r = $urandom_range(0, 99);
    if (r < 35) s = 0;
    else if (r < 55) s = $urandom_range(1, span);
    else if (r < 70) s = -int'($urandom_range(1, span));
    else if (r < 78) s = $urandom_range(0, 1) ? -1024 : 1024;
    else s = int'($urandom_range(0, 2048)) - 1024;
    r = $urandom_range(0, 99);
    if (r < 35) l = 0;
    else if (r < 75) l = $urandom_range(1, span);
    else if (r < 85) l = -1;
    else l = $urandom_range(0, 1024);
    // keep a segment that starts before the buffer within bytes written so far
    if (s < 0 && lenh + s < 0 && l > 0 && lenh + s + l > hay_hw) l = hay_hw - lenh - s;
    r = $urandom_range(0, 99);
    if (r < 50) o = $urandom_range(1, 3);
    else if (r < 65) o = $urandom_range(4, 12);
    else if (r < 75) o = 0;
    else o = int'($urandom_range(0, 2048)) - 1024;
    if (r < 65 && $urandom_range(0, 1)) o = -o;
    return make_item(MODE_SEARCH, 8'($urandom), s, l, o);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  task automatic check_result(out_t got);
    out_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with none pending", got.position, -1);
    end else begin
      want = pending_results.pop_front();
      if (got.position !== want.position)
        report_mismatch("position", got.position, want.position);
      if (got.status !== want.status)
        report_mismatch("status", got.status, want.status);
    end
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_NEEDLE_LOW:  needle_lo = val;
      REG_NEEDLE_HIGH: needle_hi = val;
      REG_NEEDLE_LEN:  needle_len = val[NLEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_needle(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi,
                            logic [NLEN_W-1:0] len);
    cfg_write(REG_NEEDLE_LOW, lo);
    cfg_write(REG_NEEDLE_HIGH, hi);
    cfg_write(REG_NEEDLE_LEN, CFG_W'(len));
    cfg_we_i <= 1'b0;
  endtask

  task automatic send(in_t t, bit fixed = 1'b0, out_t fixed_res = '0);
    out_t res;
    int   gap;
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (apply_transaction(t, res)) pending_results.push_back(fixed ? fixed_res : res);
    gap = idle_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) check_result(out_data_o);
    if (hold_pending) begin
      hold_pending = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (stall_left <= 0) begin
        stall_state = ~stall_state & ~quiet;
        if (stall_state) stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                                   : $urandom_range(8, 30);
        else stall_left = quiet ? 20 : $urandom_range(1, 12);
      end
      stall_left--;
      out_stall_i <= stall_state;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    string             pattern;
    int                rand_items, phase, n_app, n_srch, r;
    logic [7:0]        a0, a1;
    logic [2*CFG_W-1:0] nb;
    logic [NLEN_W-1:0] nlen;
    in_t               t;

    pattern = "aaabaab";
    add_row(MODE_SEARCH, 8'h00, 0, 0, 1, 1'b1, 0, 1'b0);
    add_row(MODE_UNUSED, 8'hA5, 5, 5, 5);
    add_row(MODE_CLEAR, 8'h00, 0, 0, 0);
    for (int i = 0; i < pattern.len(); i++) add_row(MODE_APPEND, pattern[i], 0, 0, 0);
    add_row(MODE_APPEND, 8'h00, 0, 0, 0);
    add_row(MODE_APPEND, 8'hFF, 0, 0, 0);
    add_row(MODE_SEARCH, 8'h00, 0, 0, 1);
    add_row(MODE_SEARCH, 8'h00, 0, 0, 2);
    add_row(MODE_SEARCH, 8'h00, 0, 0, -1);
    add_row(MODE_SEARCH, 8'h00, 1, -1, 1, 1'b1, 0, 1'b1);
    add_row(MODE_SEARCH, 8'h00, 1, 0, 0, 1'b1, 0, 1'b0);
    add_row(MODE_SEARCH, 8'h00, 1024, 0, 1, 1'b1, 0, 1'b0);
    add_row(MODE_SEARCH, 8'h00, -1024, 0, 1);
    add_row(MODE_SEARCH, 8'h00, -1024, 5, 1, 1'b1, 0, 1'b0);
    add_row(MODE_SEARCH, 8'h00, -3, 1024, -1);
    add_row(MODE_SEARCH, 8'h00, 3, 4, -1);
    add_row(MODE_SEARCH, 8'h00, 0, 1024, -1024);
    add_row(MODE_SEARCH, 8'h00, 0, 2, 1, 1'b1, 0, 1'b0);
    add_row(MODE_SEARCH, 8'h00, 0, 1024, 1024);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_needle(64'h0000_0000_0062_6161, '0, NLEN_W'(3));
    foreach (dir_rows[i]) send(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].result);

    rand_items = 0;
    phase      = 0;
    while (rand_items < RANDOM_ITEMS) begin
      drain();
      quiet = (phase > 5) && ($urandom_range(0, 5) == 0);
      a0 = $urandom;
      a1 = $urandom;
      for (int k = 0; k < 16; k++)
        nb[8*k +: 8] = ($urandom_range(0, 9) < 8) ? ($urandom_range(0, 1) ? a1 : a0)
                                                  : 8'($urandom);
      if (phase % 9 == 4) begin
        nb = '1;
        a0 = 8'hFF;
      end else if (phase % 9 == 7) begin
        nb = '0;
        a0 = 8'h00;
      end
      r = $urandom_range(0, 99);
      if (phase == 1) nlen = NLEN_W'(31);
      else if (phase == 2) nlen = NLEN_W'(NEEDLE_MAX);
      else if (phase == 3) nlen = '0;
      else if (r < 5) nlen = '0;
      else if (r < 75) nlen = NLEN_W'($urandom_range(1, 3));
      else if (r < 95) nlen = NLEN_W'($urandom_range(4, NEEDLE_MAX));
      else nlen = NLEN_W'($urandom_range(NEEDLE_MAX + 1, 31));
      set_needle(nb[CFG_W-1:0], nb[2*CFG_W-1:CFG_W], nlen);

      if ($urandom_range(0, 9) != 0) begin
        send(make_item(MODE_CLEAR, 8'($urandom), 0, 0, 0));
        rand_items++;
      end
      if ($urandom_range(0, 9) == 0) n_app = $urandom_range(49, 120);
      else n_app = $urandom_range(0, 48);
      for (int i = 0; i < n_app; i++) begin
        send(make_item(MODE_APPEND, ($urandom_range(0, 9) == 0) ? 8'($urandom)
                       : ($urandom_range(0, 1) ? a1 : a0), 0, 0, 0));
        rand_items++;
      end

      if (phase == 2) hold_pending = 1'b1;
      n_srch = (phase == 2) ? 20 : $urandom_range(6, 16);
      for (int i = 0; i < n_srch; i++) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          send(make_item(MODE_UNUSED, 8'($urandom), 0, 0, 0));
        end else begin
          if (r < 12) t = make_item(MODE_APPEND, $urandom_range(0, 1) ? a1 : a0, 0, 0, 0);
          else t = random_search(hay_len);
          send(t);
          rand_items++;
        end
      end
      phase++;
    end

    drain();
    repeat (32) @(posedge clk_i);
    err_count += pending_results.size();
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
